// ===== hw/rtl/fbpa_pkg.sv =====
// shared widths, codes and state type of the fixed block pool allocator
package fbpa_pkg;

	// pool geometry
	localparam int POOL_BLOCKS = 1024;
	localparam int IDX_W       = $clog2(POOL_BLOCKS);
	localparam int WORD_W      = 32;
	localparam int NUM_WORDS   = POOL_BLOCKS / WORD_W;
	localparam int WSEL_W      = $clog2(NUM_WORDS);
	localparam int BSEL_W      = $clog2(WORD_W);

	// field widths
	localparam int SIZE_W = 24;
	localparam int CNT_W  = 11;
	localparam int TOT_W  = 34;
	localparam int PCT_W  = 15;
	localparam int PROD_W = CNT_W + SIZE_W;
	localparam int NUM_W  = TOT_W + PCT_W;

	// waste percentage scale: 100 percent times 256
	localparam int PCT_SCALE = 25600;

	// reset values of the configuration registers
	localparam logic [SIZE_W-1:0] BLOCK_BYTES_RST = SIZE_W'(4096);
	localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = CNT_W'(POOL_BLOCKS);
	localparam logic [CNT_W-1:0]  BLOCK_COUNT_MAX = CNT_W'(POOL_BLOCKS);

	// configuration register indexes
	typedef enum logic {
		CFG_BLOCK_BYTES = 1'b0,
		CFG_BLOCK_COUNT = 1'b1
	} cfg_idx_t;

	// operation codes
	typedef enum logic [1:0] {
		FUNC_ALLOC = 2'd0,
		FUNC_FREE  = 2'd1,
		FUNC_QUERY = 2'd2
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_ALLOC_FAIL = 2'd1,
		STAT_RANGE      = 2'd2
	} status_t;

	// control sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_MUL,
		ST_WASTE,
		ST_SCALE,
		ST_DIV_GO,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ===== hw/rtl/fbpa_ram.sv =====
// generic simple dual port ram with registered read
module fbpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/fbpa_div.sv =====
// restoring divider for the waste percentage, one quotient bit per cycle
module fbpa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fbpa_pkg::NUM_W-1:0]    num,
	input  logic [fbpa_pkg::TOT_W-1:0]    den,
	output logic                          done,
	output logic [fbpa_pkg::PCT_W-1:0]    quot
);

	localparam int CNT_BITS = $clog2(fbpa_pkg::PCT_W + 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_BITS-1:0]           cnt_q;
	logic [fbpa_pkg::TOT_W-1:0]    rem_q;
	logic [fbpa_pkg::PCT_W-1:0]    low_q;
	logic [fbpa_pkg::TOT_W-1:0]    den_q;
	logic [fbpa_pkg::TOT_W:0]      trial;
	logic                          ge;
	logic [fbpa_pkg::TOT_W-1:0]    rem_next;

	// one restoring step: shift in the next numerator bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, low_q[fbpa_pkg::PCT_W-1]};
		ge       = trial >= {1'b0, den_q};
		rem_next = ge ? fbpa_pkg::TOT_W'(trial - {1'b0, den_q})
		              : trial[fbpa_pkg::TOT_W-1:0];
	end

	// control: iteration count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(fbpa_pkg::PCT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: high part of the numerator is already below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[fbpa_pkg::NUM_W-1:fbpa_pkg::PCT_W];
			low_q <= num[fbpa_pkg::PCT_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_next;
			low_q <= {low_q[fbpa_pkg::PCT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = low_q;

endmodule

// ===== hw/rtl/fixed_block_pool_allocator_unit.sv =====
// top level of the fixed block pool allocator with bitmap first fit search
//
// channel  | dir | handshake          | content
// s_*      | in  | s_tvalid/s_tready  | tuser: func; tdata: request_bytes, free_index
// m_*      | out | m_tvalid/m_tready  | tdata: status, index, count, totals, waste
// cfg_*    | in  | cfg_we             | cfg_addr selects block_bytes or block_count
//
// one item at a time: lookup, multiply, waste, scale and the bit serial
// waste divider all run before the next accept.
// the busy map lives in a 32 x 32 ram, each row with a valid bit and a
// full bit in flops, so reset takes effect at once with no clearing pass.
// the output register lets the next item in while a result waits; a
// second finished result holds in the last state until m_tready.
module fixed_block_pool_allocator_unit (
	input  logic         clk,
	input  logic         arst_n,
	// config write port
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [23:0]  cfg_data,
	// input items
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // request_bytes[23:0], free_index[33:24], zero pad
	input  logic [1:0]   s_tuser,   // func[1:0]
	// result items
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata    // status[1:0], granted_index[11:2], used_blocks[22:12],
	                                // requested_total[56:23], granted_total[90:57],
	                                // waste_percent[105:91], zero pad
);

	localparam int SIZE_W = fbpa_pkg::SIZE_W;
	localparam int CNT_W  = fbpa_pkg::CNT_W;
	localparam int TOT_W  = fbpa_pkg::TOT_W;
	localparam int PCT_W  = fbpa_pkg::PCT_W;
	localparam int IDX_W  = fbpa_pkg::IDX_W;
	localparam int WORD_W = fbpa_pkg::WORD_W;
	localparam int WSEL_W = fbpa_pkg::WSEL_W;
	localparam int BSEL_W = fbpa_pkg::BSEL_W;
	localparam int NUM_W  = fbpa_pkg::NUM_W;
	localparam int PROD_W = fbpa_pkg::PROD_W;

	// lowest zero bit of a word, with a found flag on top
	function automatic logic [BSEL_W:0] find_zero(input logic [WORD_W-1:0] w);
		logic [BSEL_W:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r = {1'b1, BSEL_W'(i)};
			end
		end
		return r;
	endfunction

	fbpa_pkg::state_t state_q, state_d;

	// configuration
	logic [SIZE_W-1:0] block_bytes_q;
	logic [CNT_W-1:0]  block_count_q;
	logic [CNT_W-1:0]  limit;

	// item registers
	logic [1:0]         func_q;
	logic [SIZE_W-1:0]  req_q;
	logic [IDX_W-1:0]   fidx_q;
	logic               req_fit_q;
	logic [WSEL_W-1:0]  wsel_q;

	// pool state in flops
	logic [fbpa_pkg::NUM_WORDS-1:0] row_vld_q;
	logic [fbpa_pkg::NUM_WORDS-1:0] row_full_q;
	logic [CNT_W-1:0]               busy_count_q;
	logic [TOT_W-1:0]               asked_sum_q;

	// statistics datapath
	logic [TOT_W-1:0] granted_q;
	logic [TOT_W-1:0] waste_q;
	logic [NUM_W-1:0] num_q;
	logic [PROD_W-1:0] prod;

	// result of the lookup step
	logic [1:0]       status_q;
	logic [IDX_W-1:0] gidx_q;

	// output register
	logic             m_tvalid_q;
	logic [1:0]       o_status_q;
	logic [IDX_W-1:0] o_gidx_q;
	logic [CNT_W-1:0] o_used_q;
	logic [TOT_W-1:0] o_req_tot_q;
	logic [TOT_W-1:0] o_gr_tot_q;
	logic [PCT_W-1:0] o_pct_q;

	// memory ports
	logic              map_we;
	logic [WSEL_W-1:0] map_raddr;
	logic [WORD_W-1:0] map_wdata;
	logic [WORD_W-1:0] map_rdata;
	logic              size_we;
	logic [IDX_W-1:0]  size_raddr;
	logic [SIZE_W-1:0] size_rdata;

	// fsm outputs and divider
	logic              accept;
	logic              div_start;
	logic              div_done;
	logic [PCT_W-1:0]  div_quot;
	logic              out_load;

	// lookup step signals
	logic [WORD_W-1:0] word;
	logic [BSEL_W:0]   zero_hit;
	logic [BSEL_W:0]   row_hit;
	logic [IDX_W-1:0]  alloc_idx;
	logic              alloc_ok;
	logic              free_in_range;
	logic              free_busy;
	logic [WORD_W-1:0] alloc_word;
	logic [WORD_W-1:0] free_word;

	// usable block count, saturated to the pool size
	assign limit = (block_count_q > fbpa_pkg::BLOCK_COUNT_MAX) ?
		fbpa_pkg::BLOCK_COUNT_MAX : block_count_q;

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= fbpa_pkg::BLOCK_BYTES_RST;
			block_count_q <= fbpa_pkg::BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			unique case (fbpa_pkg::cfg_idx_t'(cfg_addr))
				fbpa_pkg::CFG_BLOCK_BYTES: block_bytes_q <= cfg_data[SIZE_W-1:0];
				fbpa_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

	// fsm next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbpa_pkg::ST_IDLE:   if (s_tvalid) state_d = fbpa_pkg::ST_LOOKUP;
			fbpa_pkg::ST_LOOKUP: state_d = fbpa_pkg::ST_MUL;
			fbpa_pkg::ST_MUL:    state_d = fbpa_pkg::ST_WASTE;
			fbpa_pkg::ST_WASTE:  state_d = fbpa_pkg::ST_SCALE;
			fbpa_pkg::ST_SCALE:  state_d = fbpa_pkg::ST_DIV_GO;
			fbpa_pkg::ST_DIV_GO: state_d = fbpa_pkg::ST_DIV;
			fbpa_pkg::ST_DIV:    if (div_done) state_d = fbpa_pkg::ST_OUT;
			fbpa_pkg::ST_OUT:    if (!m_tvalid_q || m_tready) state_d = fbpa_pkg::ST_IDLE;
			default:             state_d = fbpa_pkg::ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			fbpa_pkg::ST_IDLE:   s_tready  = 1'b1;
			fbpa_pkg::ST_DIV_GO: div_start = 1'b1;
			fbpa_pkg::ST_OUT:    out_load  = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// read addresses issued at accept: first non-full row, or the row to free
	assign row_hit    = find_zero(row_full_q);
	assign map_raddr  = (s_tuser == fbpa_pkg::FUNC_FREE) ?
		s_tdata[24+IDX_W-1 -: WSEL_W] : row_hit[WSEL_W-1:0];
	assign size_raddr = s_tdata[24+IDX_W-1:24];

	// capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= s_tuser;
			req_q     <= s_tdata[SIZE_W-1:0];
			fidx_q    <= s_tdata[24+IDX_W-1:24];
			req_fit_q <= s_tdata[SIZE_W-1:0] <= block_bytes_q;
			wsel_q    <= map_raddr;
		end
	end

	// lookup step: rows never written read as all free
	always_comb begin
		word          = row_vld_q[wsel_q] ? map_rdata : '0;
		zero_hit      = find_zero(word);
		alloc_idx     = {wsel_q, zero_hit[BSEL_W-1:0]};
		alloc_ok      = req_fit_q && zero_hit[BSEL_W] &&
			({1'b0, alloc_idx} < limit);
		free_in_range = {1'b0, fidx_q} < limit;
		free_busy     = word[fidx_q[BSEL_W-1:0]];
		alloc_word    = word | (WORD_W'(1) << zero_hit[BSEL_W-1:0]);
		free_word     = word & ~(WORD_W'(1) << fidx_q[BSEL_W-1:0]);
	end

	// memory writes of the lookup step
	always_comb begin
		map_we    = 1'b0;
		map_wdata = alloc_word;
		size_we   = 1'b0;
		if (state_q == fbpa_pkg::ST_LOOKUP) begin
			case (func_q)
				fbpa_pkg::FUNC_ALLOC: begin
					map_we  = alloc_ok;
					size_we = alloc_ok;
				end
				fbpa_pkg::FUNC_FREE: begin
					map_we    = free_in_range && free_busy;
					map_wdata = free_word;
				end
				default: ;
			endcase
		end
	end

	// pool counters and row summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q    <= '0;
			row_full_q   <= '0;
			busy_count_q <= '0;
			asked_sum_q  <= '0;
		end else if (state_q == fbpa_pkg::ST_LOOKUP) begin
			if (map_we) begin
				row_vld_q[wsel_q]  <= 1'b1;
				row_full_q[wsel_q] <= &map_wdata;
			end
			case (func_q)
				fbpa_pkg::FUNC_ALLOC: begin
					if (alloc_ok) begin
						busy_count_q <= busy_count_q + CNT_W'(1);
						asked_sum_q  <= asked_sum_q + TOT_W'(req_q);
					end
				end
				fbpa_pkg::FUNC_FREE: begin
					if (free_in_range && free_busy) begin
						busy_count_q <= busy_count_q - CNT_W'(1);
						asked_sum_q  <= asked_sum_q - TOT_W'(size_rdata);
					end
				end
				default: ;
			endcase
		end
	end

	// status and granted index of the lookup step
	always_ff @(posedge clk) begin
		if (state_q == fbpa_pkg::ST_LOOKUP) begin
			status_q <= fbpa_pkg::STAT_OK;
			gidx_q   <= '0;
			case (func_q)
				fbpa_pkg::FUNC_ALLOC: begin
					if (alloc_ok) begin
						gidx_q <= alloc_idx;
					end else begin
						status_q <= fbpa_pkg::STAT_ALLOC_FAIL;
					end
				end
				fbpa_pkg::FUNC_FREE: begin
					if (!free_in_range) begin
						status_q <= fbpa_pkg::STAT_RANGE;
					end
				end
				default: ;
			endcase
		end
	end

	// statistics: granted bytes, waste, scaled numerator
	assign prod = PROD_W'(busy_count_q) * PROD_W'(block_bytes_q);

	always_ff @(posedge clk) begin
		if (state_q == fbpa_pkg::ST_MUL) begin
			granted_q <= prod[TOT_W-1:0];
		end
		if (state_q == fbpa_pkg::ST_WASTE) begin
			waste_q <= (asked_sum_q < granted_q) ? granted_q - asked_sum_q : '0;
		end
		if (state_q == fbpa_pkg::ST_SCALE) begin
			num_q <= NUM_W'(waste_q) * NUM_W'(fbpa_pkg::PCT_SCALE);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_status_q  <= status_q;
			o_gidx_q    <= gidx_q;
			o_used_q    <= busy_count_q;
			o_req_tot_q <= asked_sum_q;
			o_gr_tot_q  <= granted_q;
			o_pct_q     <= (waste_q == '0) ? '0 : div_quot;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, o_pct_q, o_gr_tot_q, o_req_tot_q, o_used_q, o_gidx_q, o_status_q};

	// busy map, one bit per block, 32 blocks per row
	fbpa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(fbpa_pkg::NUM_WORDS)
	) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (wsel_q),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// requested size of each busy block
	fbpa_ram #(
		.WIDTH(SIZE_W),
		.DEPTH(fbpa_pkg::POOL_BLOCKS)
	) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (alloc_idx),
		.wdata (req_q),
		.raddr (size_raddr),
		.rdata (size_rdata)
	);

	// waste percentage divider
	fbpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (granted_q),
		.done   (div_done),
		.quot   (div_quot)
	);

endmodule
